>>> design/x86enc_pkg.sv
// Shared types, codes and constants of the x86-64 instruction encoder.
`default_nettype none

package x86enc_pkg;

  localparam int unsigned MaxBytes = 11;
  localparam int unsigned BufBits  = 8 * MaxBytes;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_LEA = 2'd2;

  localparam logic [7:0] REX_W     = 8'h48;
  localparam logic [7:0] REX_PLAIN = 8'h40;
  localparam logic [7:0] OPSIZE    = 8'h66;
  localparam logic [7:0] ESC_0F    = 8'h0f;

  localparam logic [1:0] RM_REG  = 2'd0;
  localparam logic [1:0] RM_MEM  = 2'd1;
  localparam logic [1:0] RM_DISP = 2'd2;

  typedef enum logic [4:0] {
    OP_MOV_STORE   = 5'd0,
    OP_MOV_LOAD    = 5'd1,
    OP_MOV_RM_IMM  = 5'd2,
    OP_MOV_R_IMM   = 5'd3,
    OP_MOVZX_16_8  = 5'd4,
    OP_MOVZX_32_8  = 5'd5,
    OP_MOVZX_32_16 = 5'd6,
    OP_LEA         = 5'd7,
    OP_LEA_STRING  = 5'd8,
    OP_ADD         = 5'd9,
    OP_SUB         = 5'd10,
    OP_IMUL        = 5'd11,
    OP_IMUL_IMM    = 5'd12,
    OP_IDIV        = 5'd13,
    OP_CQO         = 5'd14,
    OP_PUSH        = 5'd15,
    OP_POP         = 5'd16,
    OP_JMP         = 5'd17,
    OP_JE          = 5'd18,
    OP_JNE         = 5'd19,
    OP_TEST        = 5'd20,
    OP_CMP         = 5'd21,
    OP_SETE        = 5'd22,
    OP_SETNE       = 5'd23,
    OP_SYSCALL     = 5'd24,
    OP_CALL        = 5'd25,
    OP_LEAVE       = 5'd26,
    OP_RET         = 5'd27
  } op_t;

  typedef struct packed {
    logic [BufBits-1:0] bytes;
    logic [3:0]         count;
    logic [1:0]         status;
  } enc_t;

endpackage

`default_nettype wire

>>> design/x86enc_encoder.sv
// Combinational encoder: one registered request to a packed byte string.
`default_nettype none

module x86enc_encoder (
  input  wire logic [4:0]  operation,
  input  wire logic [3:0]  operand_bytes,
  input  wire logic [2:0]  reg_field_register,
  input  wire logic [1:0]  rm_mode,
  input  wire logic [2:0]  rm_register,
  input  wire logic [31:0] displacement,
  input  wire logic [63:0] immediate,
  output x86enc_pkg::enc_t enc
);

  logic [15:0] pre;
  logic [1:0]  npre;
  logic [15:0] opc;
  logic [1:0]  nopc;
  logic        has_mod;
  logic        std_mod;
  logic [1:0]  mmode;
  logic [2:0]  mbase;
  logic [2:0]  mreg;
  logic        has_disp;
  logic [31:0] disp_val;
  logic [3:0]  nimm;
  logic [63:0] imm_val;
  logic [1:0]  st;
  logic [7:0]  modrm;
  logic [1:0]  mod_bits;
  logic        uses_rm;
  logic        sz_ok;
  logic        rm_byte_reg;
  logic [3:0]  pos0, pos1, pos2, pos3;
  logic [x86enc_pkg::BufBits-1:0] vec;

  always_comb begin
    pre      = 16'h0000;
    npre     = 2'd0;
    opc      = 16'h0000;
    nopc     = 2'd1;
    has_mod  = 1'b0;
    std_mod  = 1'b0;
    mmode    = rm_mode;
    mbase    = rm_register;
    mreg     = reg_field_register;
    has_disp = 1'b0;
    disp_val = 32'h0;
    nimm     = 4'd0;
    st       = x86enc_pkg::ST_OK;

    rm_byte_reg = (rm_mode == x86enc_pkg::RM_REG) && rm_register[2];
    sz_ok = (operand_bytes == 4'd1) || (operand_bytes == 4'd2) ||
            (operand_bytes == 4'd4) || (operand_bytes == 4'd8);
    uses_rm = (operation <= 5'd2) || ((operation >= 5'd4) && (operation <= 5'd7)) ||
              ((operation >= 5'd9) && (operation <= 5'd13)) ||
              (operation == 5'd15) || (operation == 5'd16) ||
              ((operation >= 5'd20) && (operation <= 5'd23));

    unique case (operation)
      x86enc_pkg::OP_MOV_STORE, x86enc_pkg::OP_MOV_LOAD: begin
        std_mod = 1'b1;
        if (operand_bytes == 4'd8) begin
          pre = {8'h00, x86enc_pkg::REX_W}; npre = 2'd1;
        end else if (operand_bytes == 4'd2) begin
          pre = {8'h00, x86enc_pkg::OPSIZE}; npre = 2'd1;
        end else if ((operand_bytes == 4'd1) && (reg_field_register[2] || rm_byte_reg)) begin
          pre = {8'h00, x86enc_pkg::REX_PLAIN}; npre = 2'd1;
        end
        if (operation == x86enc_pkg::OP_MOV_STORE) begin
          opc = (operand_bytes == 4'd1) ? 16'h0088 : 16'h0089;
        end else begin
          opc = (operand_bytes == 4'd1) ? 16'h008a : 16'h008b;
        end
      end
      x86enc_pkg::OP_MOV_RM_IMM: begin
        std_mod = 1'b1;
        mreg = 3'd0;
        if (operand_bytes == 4'd8) begin
          pre = {8'h00, x86enc_pkg::REX_W}; npre = 2'd1;
        end else if (operand_bytes == 4'd2) begin
          pre = {8'h00, x86enc_pkg::OPSIZE}; npre = 2'd1;
        end
        opc = 16'h00c7;
        nimm = (operand_bytes == 4'd2) ? 4'd2 : 4'd4;
      end
      x86enc_pkg::OP_MOV_R_IMM: begin
        if (operand_bytes == 4'd8) begin
          pre = {8'h00, x86enc_pkg::REX_W}; npre = 2'd1;
          opc = {8'h00, 8'hb8 + {5'd0, reg_field_register}};
          nimm = 4'd8;
        end else if ((operand_bytes == 4'd4) || (operand_bytes == 4'd2)) begin
          if (operand_bytes == 4'd2) begin
            pre = {8'h00, x86enc_pkg::OPSIZE}; npre = 2'd1;
          end
          opc = 16'h00c7;
          has_mod = 1'b1;
          mmode = x86enc_pkg::RM_REG;
          mbase = reg_field_register;
          mreg = 3'd0;
          nimm = operand_bytes;
        end else begin
          if (reg_field_register[2]) begin
            pre = {8'h00, x86enc_pkg::REX_PLAIN}; npre = 2'd1;
          end
          opc = {8'h00, 8'hb0 + {5'd0, reg_field_register}};
          nimm = 4'd1;
        end
      end
      x86enc_pkg::OP_MOVZX_16_8: begin
        std_mod = 1'b1;
        if (rm_byte_reg) begin
          pre = {x86enc_pkg::REX_PLAIN, x86enc_pkg::OPSIZE}; npre = 2'd2;
        end else begin
          pre = {8'h00, x86enc_pkg::OPSIZE}; npre = 2'd1;
        end
        opc = {8'hb6, x86enc_pkg::ESC_0F}; nopc = 2'd2;
      end
      x86enc_pkg::OP_MOVZX_32_8: begin
        std_mod = 1'b1;
        if (rm_byte_reg) begin
          pre = {8'h00, x86enc_pkg::REX_PLAIN}; npre = 2'd1;
        end
        opc = {8'hb6, x86enc_pkg::ESC_0F}; nopc = 2'd2;
      end
      x86enc_pkg::OP_MOVZX_32_16: begin
        std_mod = 1'b1;
        opc = {8'hb7, x86enc_pkg::ESC_0F}; nopc = 2'd2;
      end
      x86enc_pkg::OP_LEA: begin
        std_mod = 1'b1;
        pre = {8'h00, x86enc_pkg::REX_W}; npre = 2'd1;
        opc = 16'h008d;
      end
      x86enc_pkg::OP_LEA_STRING: begin
        pre = {8'h00, x86enc_pkg::REX_W}; npre = 2'd1;
        opc = 16'h008d;
        has_mod = 1'b1;
        mmode = x86enc_pkg::RM_MEM;
        mbase = 3'd5;
        has_disp = 1'b1;
      end
      x86enc_pkg::OP_ADD: begin
        std_mod = 1'b1;
        pre = {8'h00, x86enc_pkg::REX_W}; npre = 2'd1;
        opc = 16'h0001;
      end
      x86enc_pkg::OP_SUB: begin
        std_mod = 1'b1;
        pre = {8'h00, x86enc_pkg::REX_W}; npre = 2'd1;
        opc = 16'h0029;
      end
      x86enc_pkg::OP_IMUL: begin
        std_mod = 1'b1;
        pre = {8'h00, x86enc_pkg::REX_W}; npre = 2'd1;
        opc = {8'haf, x86enc_pkg::ESC_0F}; nopc = 2'd2;
      end
      x86enc_pkg::OP_IMUL_IMM: begin
        std_mod = 1'b1;
        pre = {8'h00, x86enc_pkg::REX_W}; npre = 2'd1;
        opc = 16'h0069;
        nimm = 4'd4;
      end
      x86enc_pkg::OP_IDIV: begin
        std_mod = 1'b1;
        mreg = 3'd7;
        pre = {8'h00, x86enc_pkg::REX_W}; npre = 2'd1;
        opc = 16'h00f7;
      end
      x86enc_pkg::OP_CQO: begin
        pre = {8'h00, x86enc_pkg::REX_W}; npre = 2'd1;
        opc = 16'h0099;
      end
      x86enc_pkg::OP_PUSH: begin
        std_mod = 1'b1;
        mreg = 3'd6;
        opc = 16'h00ff;
      end
      x86enc_pkg::OP_POP: begin
        std_mod = 1'b1;
        mreg = 3'd0;
        opc = 16'h008f;
      end
      x86enc_pkg::OP_JMP: begin
        opc = 16'h00e9;
        has_disp = 1'b1;
      end
      x86enc_pkg::OP_JE: begin
        opc = {8'h84, x86enc_pkg::ESC_0F}; nopc = 2'd2;
        has_disp = 1'b1;
      end
      x86enc_pkg::OP_JNE: begin
        opc = {8'h85, x86enc_pkg::ESC_0F}; nopc = 2'd2;
        has_disp = 1'b1;
      end
      x86enc_pkg::OP_TEST: begin
        std_mod = 1'b1;
        pre = {8'h00, x86enc_pkg::REX_W}; npre = 2'd1;
        opc = 16'h0085;
      end
      x86enc_pkg::OP_CMP: begin
        std_mod = 1'b1;
        pre = {8'h00, x86enc_pkg::REX_W}; npre = 2'd1;
        opc = 16'h0039;
      end
      x86enc_pkg::OP_SETE, x86enc_pkg::OP_SETNE: begin
        std_mod = 1'b1;
        mreg = 3'd0;
        if (rm_byte_reg) begin
          pre = {8'h00, x86enc_pkg::REX_PLAIN}; npre = 2'd1;
        end
        opc = (operation == x86enc_pkg::OP_SETE) ? {8'h94, x86enc_pkg::ESC_0F} :
                                                   {8'h95, x86enc_pkg::ESC_0F};
        nopc = 2'd2;
      end
      x86enc_pkg::OP_SYSCALL: begin
        opc = {8'h05, x86enc_pkg::ESC_0F}; nopc = 2'd2;
      end
      x86enc_pkg::OP_CALL: begin
        opc = 16'h00e8;
        has_disp = 1'b1;
      end
      x86enc_pkg::OP_LEAVE: begin
        opc = 16'h00c9;
      end
      x86enc_pkg::OP_RET: begin
        opc = 16'h00c3;
      end
      default: begin
        st = x86enc_pkg::ST_BAD;
      end
    endcase

    if (std_mod) begin
      has_mod = 1'b1;
      if (rm_mode == x86enc_pkg::RM_DISP) begin
        has_disp = 1'b1;
        disp_val = displacement;
      end
    end

    if (operation > 5'd27) begin
      st = x86enc_pkg::ST_BAD;
    end else if (uses_rm && (rm_mode == 2'd3)) begin
      st = x86enc_pkg::ST_BAD;
    end else if (((operation == x86enc_pkg::OP_MOV_STORE) ||
                  (operation == x86enc_pkg::OP_MOV_LOAD) ||
                  (operation == x86enc_pkg::OP_MOV_R_IMM)) && !sz_ok) begin
      st = x86enc_pkg::ST_BAD;
    end else if ((operation == x86enc_pkg::OP_MOV_RM_IMM) &&
                 !((operand_bytes == 4'd2) || (operand_bytes == 4'd4) ||
                   (operand_bytes == 4'd8))) begin
      st = x86enc_pkg::ST_BAD;
    end else if ((operation == x86enc_pkg::OP_LEA) && (rm_mode == x86enc_pkg::RM_REG)) begin
      st = x86enc_pkg::ST_LEA;
    end

    unique case (mmode)
      x86enc_pkg::RM_REG:  mod_bits = 2'b11;
      x86enc_pkg::RM_MEM:  mod_bits = 2'b00;
      default:             mod_bits = 2'b10;
    endcase
    modrm = {mod_bits, mreg, mbase};

    unique case (nimm)
      4'd1:    imm_val = {56'd0, immediate[7:0]};
      4'd2:    imm_val = {48'd0, immediate[15:0]};
      4'd4:    imm_val = {32'd0, immediate[31:0]};
      4'd8:    imm_val = immediate;
      default: imm_val = 64'd0;
    endcase

    pos0 = {2'b00, npre};
    pos1 = pos0 + {2'b00, nopc};
    pos2 = pos1 + {3'b000, has_mod};
    pos3 = pos2 + (has_disp ? 4'd4 : 4'd0);

    vec = x86enc_pkg::BufBits'(pre);
    vec = vec | (x86enc_pkg::BufBits'(opc) << {pos0, 3'b000});
    if (has_mod) begin
      vec = vec | (x86enc_pkg::BufBits'(modrm) << {pos1, 3'b000});
    end
    vec = vec | (x86enc_pkg::BufBits'(disp_val) << {pos2, 3'b000});
    vec = vec | (x86enc_pkg::BufBits'(imm_val) << {pos3, 3'b000});

    if (st != x86enc_pkg::ST_OK) begin
      enc.bytes  = '0;
      enc.count  = 4'd1;
      enc.status = st;
    end else begin
      enc.bytes  = vec;
      enc.count  = pos3 + nimm;
      enc.status = x86enc_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire

>>> design/x86enc_serializer.sv
// Output byte buffer: shifts an encoded instruction out one byte per item.
`default_nettype none

module x86enc_serializer (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire x86enc_pkg::enc_t enc,
  output logic                  can_load,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            code_byte,
  output logic                  last_byte,
  output logic [1:0]            status
);

  logic [x86enc_pkg::BufBits-1:0] bytes;
  logic [3:0]                     remaining;
  logic [1:0]                     st;
  logic                           busy;
  logic                           take;

  assign take      = busy && out_ready;
  assign last_byte = (remaining == 4'd1);
  assign can_load  = !busy || (out_ready && last_byte);
  assign out_valid = busy;
  assign code_byte = bytes[7:0];
  assign status    = st;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (take && last_byte) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes     <= enc.bytes;
      remaining <= enc.count;
      st        <= enc.status;
    end else if (take) begin
      bytes     <= bytes >> 8;
      remaining <= remaining - 4'd1;
    end
  end

endmodule

`default_nettype wire

>>> design/x86_instruction_encoder_unit.sv
// Top level of the x86-64 instruction encoder: input register, encoder and byte buffer.
//
//   channel  direction  fields
//   in       in         operation, operand_bytes, reg_field_register, rm_mode,
//                       rm_register, displacement, immediate
//   out      out        code_byte, last_byte, status
//
// An instruction of n bytes (1 to 11) is shifted out one byte per cycle while out_ready
// is high, so the rate is set by the byte buffer; an accepted item waits in the input
// register until the buffer loads it and offers its first byte. The next item is
// taken while the current one drains, and its encoding enters the buffer at the edge
// that takes the previous last byte, so the bytes follow with no gap. Reset empties
// the input register and the byte buffer; a stalled output holds its byte.
`default_nettype none

module x86_instruction_encoder_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  operation,
  input  wire logic [3:0]  operand_bytes,
  input  wire logic [2:0]  reg_field_register,
  input  wire logic [1:0]  rm_mode,
  input  wire logic [2:0]  rm_register,
  input  wire logic [31:0] displacement,
  input  wire logic [63:0] immediate,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       code_byte,
  output logic             last_byte,
  output logic [1:0]       status
);

  logic        held;
  logic [4:0]  op_q;
  logic [3:0]  sz_q;
  logic [2:0]  rg_q;
  logic [1:0]  md_q;
  logic [2:0]  rm_q;
  logic [31:0] dp_q;
  logic [63:0] im_q;
  logic        can_load;
  logic        load;
  x86enc_pkg::enc_t enc;

  assign load     = held && can_load;
  assign in_ready = !held || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (load) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q <= operation;
      sz_q <= operand_bytes;
      rg_q <= reg_field_register;
      md_q <= rm_mode;
      rm_q <= rm_register;
      dp_q <= displacement;
      im_q <= immediate;
    end
  end

  x86enc_encoder u_encoder (
    .operation          (op_q),
    .operand_bytes      (sz_q),
    .reg_field_register (rg_q),
    .rm_mode            (md_q),
    .rm_register        (rm_q),
    .displacement       (dp_q),
    .immediate          (im_q),
    .enc                (enc)
  );

  x86enc_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .enc       (enc),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_byte (code_byte),
    .last_byte (last_byte),
    .status    (status)
  );

endmodule

`default_nettype wire
